// ===== hdl/source_map_vlq_delta_decoder_assert.svh =====
// assertion macros used by the source-map decoder core
`ifndef SOURCE_MAP_VLQ_DELTA_DECODER_ASSERT_SVH
`define SOURCE_MAP_VLQ_DELTA_DECODER_ASSERT_SVH

// condition holds at every clock edge outside reset
`define SMVD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SMVD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/smvd_pkg.sv =====
// types and constants of the source-map vlq delta decoder
package smvd_pkg;

  localparam int DATA_W = 32;
  localparam int LINE_W = 24;
  localparam int POS_W  = 3;

  // separator characters
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;

  // result kinds
  typedef enum logic [1:0] {
    KIND_VALUE = 2'd0,
    KIND_SEG   = 2'd1,
    KIND_LINE  = 2'd2,
    KIND_ERR   = 2'd3
  } kind_t;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_BAD_SYM  = 3'd1,
    ERR_OVERLONG = 3'd2,
    ERR_SIXTH    = 3'd3,
    ERR_TRUNC    = 3'd4
  } err_t;

  // class of one text byte
  typedef struct packed {
    logic       is_sep;
    logic       is_line;
    logic       sym_ok;
    logic [5:0] sym;
  } cls_t;

  // one result
  typedef struct packed {
    kind_t                     kind;
    logic signed [DATA_W-1:0]  delta;
    logic signed [DATA_W-1:0]  absolute;
    logic        [POS_W-1:0]   field_pos;
    logic        [LINE_W-1:0]  line_number;
    err_t                      error_code;
  } res_t;

endpackage

// ===== hdl/smvd_classify.sv =====
// maps a text byte to its base64 value or separator class
module smvd_classify import smvd_pkg::*; (
  input  logic [7:0] char_code,
  output cls_t       cls
);

  // base64 alphabet and separators
  always_comb begin
    cls = '0;
    if (char_code == CHAR_COMMA) begin
      cls.is_sep = 1'b1;
    end else if (char_code == CHAR_SEMI) begin
      cls.is_sep  = 1'b1;
      cls.is_line = 1'b1;
    end else if (char_code >= 8'h41 && char_code <= 8'h5A) begin
      cls.sym_ok = 1'b1;
      cls.sym    = 6'(char_code - 8'h41);
    end else if (char_code >= 8'h61 && char_code <= 8'h7A) begin
      cls.sym_ok = 1'b1;
      cls.sym    = 6'(char_code - 8'h61 + 8'd26);
    end else if (char_code >= 8'h30 && char_code <= 8'h39) begin
      cls.sym_ok = 1'b1;
      cls.sym    = 6'(char_code - 8'h30 + 8'd52);
    end else if (char_code == 8'h2B) begin
      cls.sym_ok = 1'b1;
      cls.sym    = 6'd62;
    end else if (char_code == 8'h2F) begin
      cls.sym_ok = 1'b1;
      cls.sym    = 6'd63;
    end
  end

endmodule

// ===== hdl/smvd_core.sv =====
// decode state, group accumulation and running totals
module smvd_core import smvd_pkg::*; #(
  parameter int MAX_FIELDS = 5,
  parameter int MAX_GROUPS = 7
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] char_code,
  output logic       res_valid,
  output res_t       res
);

  `include "source_map_vlq_delta_decoder_assert.svh"

  localparam int FC_W = $clog2(MAX_FIELDS + 1);
  localparam int IX_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

  cls_t cls;

  logic [DATA_W-1:0] partial_value, partial_value_next;
  logic [2:0]        group_count, group_count_next;
  logic [FC_W-1:0]   field_counter, field_counter_next;
  logic [LINE_W-1:0] line_counter, line_counter_next;
  logic [DATA_W-1:0] running_totals [MAX_FIELDS];

  logic              tot_wr;
  logic [IX_W-1:0]   tot_idx;
  logic [DATA_W-1:0] tot_data;
  logic              tot_clr0;

  logic [4:0]        shamt;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] mag;
  logic [DATA_W-1:0] dval;
  logic [DATA_W-1:0] sum;

  smvd_classify u_classify (
    .char_code (char_code),
    .cls       (cls)
  );

  // group accumulation and sign handling
  always_comb begin
    shamt   = {group_count, 2'b00} + {2'b00, group_count};
    acc     = partial_value | (DATA_W'(cls.sym[4:0]) << shamt);
    mag     = acc >> 1;
    dval    = acc[0] ? (DATA_W'(0) - mag) : mag;
    tot_idx = field_counter[IX_W-1:0];
    sum     = running_totals[tot_idx] + dval;
  end

  // next state and result
  always_comb begin
    partial_value_next = partial_value;
    group_count_next   = group_count;
    field_counter_next = field_counter;
    line_counter_next  = line_counter;
    tot_wr             = 1'b0;
    tot_data           = sum;
    tot_clr0           = 1'b0;
    res_valid          = 1'b0;
    res.kind           = KIND_VALUE;
    res.delta          = '0;
    res.absolute       = '0;
    res.field_pos      = POS_W'(field_counter);
    res.line_number    = line_counter;
    res.error_code     = ERR_NONE;
    if (step) begin
      if (cls.is_sep) begin
        partial_value_next = '0;
        group_count_next   = '0;
        field_counter_next = '0;
        res_valid          = 1'b1;
        if (group_count != 3'd0) begin
          res.kind       = KIND_ERR;
          res.error_code = ERR_TRUNC;
        end else if (cls.is_line) begin
          res.kind = KIND_LINE;
        end else begin
          res.kind = KIND_SEG;
        end
        if (cls.is_line) begin
          tot_clr0 = 1'b1;
          if (line_counter != {LINE_W{1'b1}}) begin
            line_counter_next = line_counter + LINE_W'(1);
          end
        end
      end else if (!cls.sym_ok) begin
        partial_value_next = '0;
        group_count_next   = '0;
        res_valid          = 1'b1;
        res.kind           = KIND_ERR;
        res.error_code     = ERR_BAD_SYM;
      end else if (group_count >= 3'(MAX_GROUPS)) begin
        partial_value_next = '0;
        group_count_next   = '0;
        res_valid          = 1'b1;
        res.kind           = KIND_ERR;
        res.error_code     = ERR_OVERLONG;
      end else if (cls.sym[5]) begin
        // continuation: keep accumulating
        partial_value_next = acc;
        group_count_next   = group_count + 3'd1;
      end else begin
        partial_value_next = '0;
        group_count_next   = '0;
        res_valid          = 1'b1;
        if (field_counter >= FC_W'(MAX_FIELDS)) begin
          res.kind       = KIND_ERR;
          res.error_code = ERR_SIXTH;
        end else begin
          tot_wr             = 1'b1;
          field_counter_next = field_counter + FC_W'(1);
          res.delta          = dval;
          res.absolute       = sum;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value <= '0;
      group_count   <= '0;
      field_counter <= '0;
      line_counter  <= '0;
    end else begin
      partial_value <= partial_value_next;
      group_count   <= group_count_next;
      field_counter <= field_counter_next;
      line_counter  <= line_counter_next;
    end
  end

  // running totals, one per field position
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_FIELDS; i++) begin
        running_totals[i] <= '0;
      end
    end else if (tot_wr) begin
      running_totals[tot_idx] <= tot_data;
    end else if (tot_clr0) begin
      running_totals[0] <= '0;
    end
  end

  `SMVD_ASSERT_ALWAYS(a_group_bound, clk, rst, group_count <= 3'(MAX_GROUPS),
                      "group count overrun")
  `SMVD_ASSERT_ALWAYS(a_field_bound, clk, rst, field_counter <= FC_W'(MAX_FIELDS),
                      "field count overrun")
  `SMVD_ASSERT_IMPL(a_line_mono, clk, rst, !$past(rst),
                    line_counter >= $past(line_counter), "line count went back")
  `SMVD_ASSERT_IMPL(a_no_step_no_res, clk, rst, !step, !res_valid,
                    "result without request")
  `SMVD_ASSERT_IMPL(a_err_code, clk, rst, res_valid && res.kind != KIND_ERR,
                    res.error_code == ERR_NONE, "error code on non-error result")

endmodule

// ===== hdl/source_map_vlq_delta_decoder.sv =====
// top level: input register, decode core and result register
//
//  channel | signals                                    | direction
//  input   | in_valid, in_stall, char_code              | request in
//  output  | out_valid, out_stall, kind, delta,         | result out
//          | absolute, field_pos, line_number, error_code
//
// one request per cycle sustained while out_stall is low; a request's result passes through
// the input register, then decode and totals update into the result register
// synchronous reset clears totals, counters and both valid flags
// out_stall holds a valid result register and, with the input register full, raises in_stall
// separators and errors give one result each; a continuation symbol gives none
module source_map_vlq_delta_decoder import smvd_pkg::*; #(
  parameter int MAX_FIELDS = 5,
  parameter int MAX_GROUPS = 7
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               char_code,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               kind,
  output logic signed [DATA_W-1:0] delta,
  output logic signed [DATA_W-1:0] absolute,
  output logic [POS_W-1:0]         field_pos,
  output logic [LINE_W-1:0]        line_number,
  output logic [2:0]               error_code
);

  logic       in_full;
  logic [7:0] char_reg;
  logic       adv;
  logic       step;
  logic       res_valid;
  res_t       res;
  res_t       out_reg;

  // handshake control
  assign adv      = !out_valid || !out_stall;
  assign step     = in_full && adv;
  assign in_stall = in_full && !adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      char_reg <= char_code;
    end
  end

  smvd_core #(
    .MAX_FIELDS (MAX_FIELDS),
    .MAX_GROUPS (MAX_GROUPS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .char_code (char_reg),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_reg <= res;
    end
  end

  assign kind        = out_reg.kind;
  assign delta       = out_reg.delta;
  assign absolute    = out_reg.absolute;
  assign field_pos   = out_reg.field_pos;
  assign line_number = out_reg.line_number;
  assign error_code  = out_reg.error_code;

endmodule
